// ===== rtl/core/pwa_pkg.sv =====
// Shared types, widths and register codes for the periodic wavelet analysis block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package pwa_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int TAP_W     = 16;
   localparam int PROD_W    = 32;
   localparam int COEFF_W   = 36;
   localparam int PAIR_W    = 9;
   localparam int FLEN_W    = 4;
   localparam int ROW_W     = 11;
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 3;
   localparam int REG_TAPS  = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_LENGTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LENGTH       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_TAPS_FIRST   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_TAPS_SECOND  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_TAPS_FIRST  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_TAPS_SECOND = 3'd5;

   typedef struct packed {
      logic signed [COEFF_W-1:0] low_coeff;
      logic signed [COEFF_W-1:0] high_coeff;
      logic [PAIR_W-1:0]         pair_index;
      logic                      row_done;
   } rsp_word_type;

   typedef struct packed {
      logic shift_en;    // take the right neighbor's window sample
      logic load_en;     // load the wrap replay sample
      logic step_en;     // advance the replay line by two
      logic use_replay;  // multiply the replay sample instead of the window
   } cell_ctl_type;

   // Pick tap k out of two packed 64-bit words; taps past the registers read as zero.
   function automatic logic signed [TAP_W-1:0] tap_pick(input logic [CSR_W-1:0] first,
                                                        input logic [CSR_W-1:0] second,
                                                        input logic [4:0]       k);
      logic [CSR_W-1:0] word;
      logic [TAP_W-1:0] raw;
      word = k[2] ? second : first;
      raw  = word[16*k[1:0] +: 16];
      if (k >= 5'(REG_TAPS)) begin
         raw = '0;
      end
      return $signed(raw);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pwa_if.sv =====
// Valid/ready channel interfaces for the sample input and the coefficient output.
// Depends on pwa_pkg for field widths.
`default_nettype none

interface pwa_req_if;
   import pwa_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface pwa_rsp_if;
   import pwa_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [COEFF_W-1:0] low_coeff;
   logic signed [COEFF_W-1:0] high_coeff;
   logic [PAIR_W-1:0]         pair_index;
   logic                      row_done;

   modport source (output valid, output low_coeff, output high_coeff,
                   output pair_index, output row_done, input ready);
   modport sink   (input valid, input low_coeff, input high_coeff,
                   input pair_index, input row_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pwa_cell.sv =====
// One tap cell: a window stage, a wrap replay stage and the lowpass/highpass products.
// Depends on pwa_pkg.
`default_nettype none

module pwa_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  pwa_pkg::cell_ctl_type              ctl,
   input  logic signed [pwa_pkg::SAMPLE_W-1:0] next_w,
   input  logic signed [pwa_pkg::SAMPLE_W-1:0] load_v,
   input  logic signed [pwa_pkg::SAMPLE_W-1:0] next_v,
   input  logic signed [pwa_pkg::TAP_W-1:0]    tap_lo,
   input  logic signed [pwa_pkg::TAP_W-1:0]    tap_hi,
   output logic signed [pwa_pkg::SAMPLE_W-1:0] w,
   output logic signed [pwa_pkg::SAMPLE_W-1:0] v,
   output logic signed [pwa_pkg::PROD_W-1:0]   prod_lo,
   output logic signed [pwa_pkg::PROD_W-1:0]   prod_hi
);
   import pwa_pkg::*;

   logic signed [SAMPLE_W-1:0] w_ff, w_in;
   logic signed [SAMPLE_W-1:0] v_ff, v_in;
   logic signed [SAMPLE_W-1:0] operand;
   logic signed [PROD_W-1:0]   prod_lo_ff, prod_lo_in;
   logic signed [PROD_W-1:0]   prod_hi_ff, prod_hi_in;

   always_comb begin
      w_in = ctl.shift_en ? next_w : w_ff;
      if (ctl.load_en) begin
         v_in = load_v;
      end else if (ctl.step_en) begin
         v_in = next_v;
      end else begin
         v_in = v_ff;
      end
      operand    = ctl.use_replay ? v_ff : w_ff;
      prod_lo_in = operand * tap_lo;
      prod_hi_in = operand * tap_hi;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= '0;
      end else begin
         w_ff <= w_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff       <= v_in;
      prod_lo_ff <= prod_lo_in;
      prod_hi_ff <= prod_hi_in;
   end

   assign w       = w_ff;
   assign v       = v_ff;
   assign prod_lo = prod_lo_ff;
   assign prod_hi = prod_hi_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pwa_sum_tree.sv =====
// Registered binary adder tree over the cell products, one register per level.
// Depends on pwa_pkg for product and coefficient widths.
`default_nettype none

module pwa_sum_tree #(
   parameter int N_IN = 8
) (
   input  logic                              clock,
   input  logic signed [pwa_pkg::PROD_W-1:0]  leaf [N_IN],
   output logic signed [pwa_pkg::COEFF_W-1:0] sum
);
   import pwa_pkg::*;

   localparam int LEVELS = (N_IN > 1) ? $clog2(N_IN) : 1;
   localparam int P      = 1 << LEVELS;

   logic signed [COEFF_W-1:0] node    [1:2*P-1];
   logic signed [COEFF_W-1:0] node_ff [1:P-1];

   for (genvar i = 1; i < P; i++) begin : g_inner
      assign node[i] = node_ff[i];
      always_ff @(posedge clock) begin
         node_ff[i] <= node[2*i] + node[2*i+1];
      end
   end

   for (genvar i = 0; i < P; i++) begin : g_leaf
      if (i < N_IN) begin : g_used
         assign node[P+i] = COEFF_W'(leaf[i]);
      end else begin : g_pad
         assign node[P+i] = '0;
      end
   end

   assign sum = node[1];

endmodule

`default_nettype wire

// ===== rtl/core/pwa_out_fifo.sv =====
// Result FIFO with a registered output word that drives the response channel.
// Depends on pwa_pkg and the pwa_rsp_if interface.
`default_nettype none

module pwa_out_fifo #(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  pwa_pkg::rsp_word_type wr_word,
   pwa_rsp_if.source             rsp
);
   import pwa_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   rsp_word_type    mem [DEPTH];
   rsp_word_type    out_ff;
   logic            out_valid_ff, out_valid_in;
   logic [AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]     count_ff, count_in;
   logic            pop;

   // Refill the output word whenever it is empty or being taken.
   assign pop = (count_ff != '0) && (!out_valid_ff || rsp.ready);

   always_comb begin
      count_in = count_ff + (AW+1)'(wr_en) - (AW+1)'(pop);
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr_ff] <= wr_word;
      end
      if (pop) begin
         out_ff <= mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.low_coeff  = out_ff.low_coeff;
   assign rsp.high_coeff = out_ff.high_coeff;
   assign rsp.pair_index = out_ff.pair_index;
   assign rsp.row_done   = out_ff.row_done;

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (count_ff < DEPTH))
      else $error("result written into a full FIFO");

endmodule

`default_nettype wire

// ===== rtl/core/periodic_wavelet_analysis_1d.sv =====
// Periodic 1D wavelet analysis, top level: tap cell chain, adder trees and result FIFO.
// Depends on pwa_pkg, pwa_if, pwa_cell, pwa_sum_tree and pwa_out_fifo.
//
// The block takes one row sample per clock while req_port.ready is high, and returns
// the lowpass and negated highpass coefficient pairs of the periodic transform, each
// tagged with its pair index m so a store can put lows at m and highs at N/2+m. Samples
// shift through a chain of MAX_TAPS cells; each cell multiplies its sample by the tap
// that lines up with it for the current filter length, and two registered adder trees
// reduce the products. A pair that needs no wrap passes the issue, product and tree
// level registers after its completing word. The (F-2)/2 wrap pairs of a row are worked
// after its last sample: that word snapshots the window and the row's head samples into
// a replay line inside the same cells, which steps by two samples per cycle when no
// ordinary pair issues, and reuses the multipliers while the next row's first samples
// stream in, so they do not stall the input. Results queue in a FIFO of FIFO_DEPTH
// words ahead of a registered output word; the input side takes a word whenever enough
// FIFO space is reserved for the largest burst a word can cause (MAX_TAPS/2 results),
// so with the output side taking a word per cycle the input never stalls. Configuration
// is written through csr_wr_en/csr_index/csr_wdata while the block is idle, a rule for
// the user that the block does not enforce; indexes past the register list are ignored.
`default_nettype none

module periodic_wavelet_analysis_1d #(
   parameter int MAX_TAPS = 8,
   parameter int MAX_ROW  = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [pwa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pwa_pkg::CSR_W-1:0]         csr_wdata,
   pwa_req_if.sink                           req_port,
   pwa_rsp_if.source                         rsp_port
);
   import pwa_pkg::*;

   localparam int HEAD_DEPTH  = MAX_TAPS - 2;
   localparam int HS          = (HEAD_DEPTH > 0) ? HEAD_DEPTH : 1;
   localparam int HIDX_W      = (HS > 1) ? $clog2(HS) : 1;
   localparam int REP_LEN     = MAX_TAPS + HS;
   localparam int MAX_RES     = MAX_TAPS / 2;
   localparam int WRAP_W      = $clog2(MAX_RES + 1);
   localparam int TREE_LAT    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int FIFO_DEPTH  = 2 ** $clog2(2 * MAX_RES + TREE_LAT + 8);
   localparam int RES_W       = $clog2(FIFO_DEPTH + 1);
   localparam int ROW_CAP     = (MAX_ROW < 2046) ? MAX_ROW : 2046;

   localparam logic [ROW_W-1:0]  ROW_CAP_V = ROW_CAP[ROW_W-1:0];
   localparam logic [FLEN_W:0]   TAP_CAP   = MAX_TAPS[FLEN_W:0];
   localparam logic [RES_W-1:0]  RES_LIMIT = RES_W'(FIFO_DEPTH - MAX_RES);

   // ---------------- configuration registers ----------------
   logic [FLEN_W-1:0] flen_ff;
   logic [ROW_W-1:0]  rlen_ff;
   logic [CSR_W-1:0]  ltap_first_ff, ltap_second_ff;
   logic [CSR_W-1:0]  htap_first_ff, htap_second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         flen_ff        <= 4'd4;
         rlen_ff        <= 11'd1024;
         ltap_first_ff  <= '0;
         ltap_second_ff <= '0;
         htap_first_ff  <= '0;
         htap_second_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FILTER_LENGTH:    flen_ff        <= csr_wdata[FLEN_W-1:0];
            CSR_ROW_LENGTH:       rlen_ff        <= csr_wdata[ROW_W-1:0];
            CSR_LOW_TAPS_FIRST:   ltap_first_ff  <= csr_wdata;
            CSR_LOW_TAPS_SECOND:  ltap_second_ff <= csr_wdata;
            CSR_HIGH_TAPS_FIRST:  htap_first_ff  <= csr_wdata;
            CSR_HIGH_TAPS_SECOND: htap_second_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- effective row and filter length ----------------
   logic [ROW_W-1:0]  n_cap, n_even, row_n;
   logic [FLEN_W-1:0] f_cap, f_even, f_min2, filt_f;

   always_comb begin
      n_cap  = (rlen_ff > ROW_CAP_V) ? ROW_CAP_V : rlen_ff;
      n_even = {n_cap[ROW_W-1:1], 1'b0};
      row_n  = (n_even < 11'd2) ? 11'd2 : n_even;
      f_cap  = ({1'b0, flen_ff} > TAP_CAP) ? TAP_CAP[FLEN_W-1:0] : flen_ff;
      f_even = {f_cap[FLEN_W-1:1], 1'b0};
      f_min2 = (f_even < 4'd2) ? 4'd2 : f_even;
      // a row shorter than the filter trims the filter for that row
      filt_f = (ROW_W'(f_min2) > row_n) ? row_n[FLEN_W-1:0] : f_min2;
   end

   // ---------------- sample position and per-word decisions ----------------
   logic [ROW_W-1:0]          sample_count_ff, sample_count_in;
   logic [ROW_W-1:0]          pos, pos_next, ord_diff;
   logic                      req_acc, last, emit_ord, head_wr;
   logic [HIDX_W-1:0]         head_idx;
   logic [WRAP_W-1:0]         wraps_new;
   logic [RES_W-1:0]          res_ff, res_in, res_new;
   logic signed [SAMPLE_W-1:0] x;

   assign x        = req_port.sample;
   assign req_port.ready = (res_ff <= RES_LIMIT);
   assign req_acc  = req_port.valid && req_port.ready;

   always_comb begin
      // a count left past a lowered row length restarts the row
      pos       = (sample_count_ff >= row_n) ? '0 : sample_count_ff;
      pos_next  = pos + 1'b1;
      last      = (pos_next == row_n);
      emit_ord  = pos[0] && (pos_next >= ROW_W'(filt_f));
      ord_diff  = pos_next - ROW_W'(filt_f);
      head_wr   = (pos < ROW_W'(HEAD_DEPTH));
      head_idx  = pos[HIDX_W-1:0];
      wraps_new = WRAP_W'((filt_f - 4'd2) >> 1);
      res_new   = RES_W'(emit_ord) + (last ? RES_W'(wraps_new) : '0);
      sample_count_in = last ? '0 : pos_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= '0;
      end else if (req_acc) begin
         sample_count_ff <= sample_count_in;
      end
   end

   // ---------------- head store: first samples of the row ----------------
   logic signed [SAMPLE_W-1:0] head_ff   [HS];
   logic signed [SAMPLE_W-1:0] head_next [HS];

   always_ff @(posedge clock) begin
      if (req_acc && head_wr) begin
         head_ff[head_idx] <= x;
      end
   end

   always_comb begin
      for (int h = 0; h < HS; h++) begin
         head_next[h] = (head_wr && head_idx == HIDX_W'(h)) ? x : head_ff[h];
      end
   end

   // ---------------- ordinary pair and wrap sequencing ----------------
   logic                 ord_fire_ff;
   logic [PAIR_W-1:0]    ord_m_ff;
   logic                 ord_done_ff;
   logic [WRAP_W-1:0]    wrap_left_ff, wrap_left_in;
   logic [PAIR_W-1:0]    wrap_m_ff, wrap_m_in;
   logic                 wrap_fire;
   logic                 load_rep;

   // The ordinary pair of the last word goes first; wraps follow one per cycle.
   assign wrap_fire = (wrap_left_ff != '0) && !ord_fire_ff;
   assign load_rep  = req_acc && last;

   always_comb begin
      wrap_left_in = wrap_left_ff;
      wrap_m_in    = wrap_m_ff;
      if (load_rep) begin
         wrap_left_in = wraps_new;
         wrap_m_in    = row_n[PAIR_W:1] - PAIR_W'(wraps_new);
      end else if (wrap_fire) begin
         wrap_left_in = wrap_left_ff - 1'b1;
         wrap_m_in    = wrap_m_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ord_fire_ff  <= 1'b0;
         wrap_left_ff <= '0;
      end else begin
         ord_fire_ff  <= req_acc && emit_ord;
         wrap_left_ff <= wrap_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         ord_m_ff    <= ord_diff[PAIR_W:1];
         ord_done_ff <= last && (filt_f == 4'd2);
      end
      wrap_m_ff <= wrap_m_in;
   end

   // ---------------- tap alignment: tap k sits on cell MAX_TAPS-F+k ----------------
   logic signed [TAP_W-1:0] tap_lo_ff [MAX_TAPS];
   logic signed [TAP_W-1:0] tap_hi_ff [MAX_TAPS];
   logic signed [TAP_W-1:0] tap_lo_in [MAX_TAPS];
   logic signed [TAP_W-1:0] tap_hi_in [MAX_TAPS];
   logic [4:0]              tap_k     [MAX_TAPS];

   always_comb begin
      for (int i = 0; i < MAX_TAPS; i++) begin
         tap_k[i] = 5'(i) + {1'b0, filt_f} - 5'(MAX_TAPS);
         if (5'(i) + {1'b0, filt_f} >= 5'(MAX_TAPS)) begin
            tap_lo_in[i] = tap_pick(ltap_first_ff, ltap_second_ff, tap_k[i]);
            tap_hi_in[i] = tap_pick(htap_first_ff, htap_second_ff, tap_k[i]);
         end else begin
            tap_lo_in[i] = '0;
            tap_hi_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
         tap_lo_ff[i] <= tap_lo_in[i];
         tap_hi_ff[i] <= tap_hi_in[i];
      end
   end

   // ---------------- cell chain and replay line ----------------
   // Replay line: cells hold positions 0..MAX_TAPS-1, the tail holds the head copy.
   // Loading stores the post-shift window and head advanced by two, so the first
   // wrap cycle already sees the first wrap pair in the cells.
   logic signed [SAMPLE_W-1:0] cell_w   [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] cell_v   [MAX_TAPS];
   logic signed [PROD_W-1:0]   prod_lo  [MAX_TAPS];
   logic signed [PROD_W-1:0]   prod_hi  [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] tail_ff  [HS];
   logic signed [SAMPLE_W-1:0] seq_ext  [REP_LEN+2];
   logic signed [SAMPLE_W-1:0] rep_ext  [REP_LEN+2];
   cell_ctl_type               cell_ctl;

   always_comb begin
      cell_ctl.shift_en   = req_acc;
      cell_ctl.load_en    = load_rep;
      cell_ctl.step_en    = wrap_fire;
      cell_ctl.use_replay = wrap_fire;
   end

   always_comb begin
      for (int i = 0; i < MAX_TAPS - 1; i++) begin
         seq_ext[i] = cell_w[i+1];
      end
      seq_ext[MAX_TAPS-1] = x;
      for (int i = 0; i < MAX_TAPS; i++) begin
         rep_ext[i] = cell_v[i];
      end
      for (int h = 0; h < HS; h++) begin
         seq_ext[MAX_TAPS+h] = head_next[h];
         rep_ext[MAX_TAPS+h] = tail_ff[h];
      end
      seq_ext[REP_LEN]   = '0;
      seq_ext[REP_LEN+1] = '0;
      rep_ext[REP_LEN]   = '0;
      rep_ext[REP_LEN+1] = '0;
   end

   always_ff @(posedge clock) begin
      for (int h = 0; h < HS; h++) begin
         if (load_rep) begin
            tail_ff[h] <= seq_ext[MAX_TAPS+h+2];
         end else if (wrap_fire) begin
            tail_ff[h] <= rep_ext[MAX_TAPS+h+2];
         end
      end
   end

   for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
      logic signed [SAMPLE_W-1:0] right_w;
      if (i < MAX_TAPS - 1) begin : g_mid
         assign right_w = cell_w[i+1];
      end else begin : g_end
         assign right_w = x;
      end

      pwa_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (cell_ctl),
         .next_w  (right_w),
         .load_v  (seq_ext[i+2]),
         .next_v  (rep_ext[i+2]),
         .tap_lo  (tap_lo_ff[i]),
         .tap_hi  (tap_hi_ff[i]),
         .w       (cell_w[i]),
         .v       (cell_v[i]),
         .prod_lo (prod_lo[i]),
         .prod_hi (prod_hi[i])
      );
   end

   // ---------------- adder trees and result tags ----------------
   logic signed [COEFF_W-1:0] sum_lo, sum_hi;

   pwa_sum_tree #(.N_IN(MAX_TAPS)) u_tree_lo (
      .clock (clock),
      .leaf  (prod_lo),
      .sum   (sum_lo)
   );

   pwa_sum_tree #(.N_IN(MAX_TAPS)) u_tree_hi (
      .clock (clock),
      .leaf  (prod_hi),
      .sum   (sum_hi)
   );

   // Tags ride beside the products: stage 0 lines up with the product registers.
   logic [TREE_LAT:0] meta_v_ff;
   logic [PAIR_W-1:0] meta_m_ff [TREE_LAT+1];
   logic              meta_d_ff [TREE_LAT+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_v_ff <= '0;
      end else begin
         meta_v_ff <= {meta_v_ff[TREE_LAT-1:0], ord_fire_ff || wrap_fire};
      end
   end

   always_ff @(posedge clock) begin
      meta_m_ff[0] <= ord_fire_ff ? ord_m_ff : wrap_m_ff;
      meta_d_ff[0] <= ord_fire_ff ? ord_done_ff : (wrap_left_ff == WRAP_W'(1));
      for (int s = 1; s <= TREE_LAT; s++) begin
         meta_m_ff[s] <= meta_m_ff[s-1];
         meta_d_ff[s] <= meta_d_ff[s-1];
      end
   end

   // ---------------- result FIFO and space reservation ----------------
   rsp_word_type fifo_word;
   logic         fifo_wr;
   logic         rsp_acc;

   assign fifo_wr = meta_v_ff[TREE_LAT];
   assign rsp_acc = rsp_port.valid && rsp_port.ready;

   always_comb begin
      fifo_word.low_coeff  = sum_lo;
      fifo_word.high_coeff = -sum_hi;
      fifo_word.pair_index = meta_m_ff[TREE_LAT];
      fifo_word.row_done   = meta_d_ff[TREE_LAT];
   end

   pwa_out_fifo #(.DEPTH(FIFO_DEPTH)) u_out_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fifo_wr),
      .wr_word (fifo_word),
      .rsp     (rsp_port)
   );

   // Reserve space for every result a word causes when the word is taken.
   always_comb begin
      res_in = res_ff + (req_acc ? res_new : '0) - RES_W'(rsp_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
      end else begin
         res_ff <= res_in;
      end
   end

   // ---------------- checks ----------------
   a_wrap_before_next : assert property (@(posedge clock) disable iff (reset)
      (req_acc && emit_ord) |->
         (wrap_left_ff == '0 || (wrap_left_ff == WRAP_W'(1) && wrap_fire)))
      else $error("ordinary pair would overtake pending wrap pairs");

   a_idle_empty : assert property (@(posedge clock) disable iff (reset)
      (res_ff == '0) |->
         (!rsp_port.valid && meta_v_ff == '0 && !ord_fire_ff && wrap_left_ff == '0))
      else $error("work in flight with no reserved result space");

endmodule

`default_nettype wire
